>>> rtl/frame_number_overlay_top_assert.svh
// Assertion macros for the frame number overlay.
`ifndef FRAME_NUMBER_OVERLAY_TOP_ASSERT_SVH
`define FRAME_NUMBER_OVERLAY_TOP_ASSERT_SVH

// Same-cycle implication.
`define FNO_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FNO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fno_pkg.sv
package fno_pkg;

	localparam int MAX_DIGITS_DEF = 20;
	localparam int NUM_DIGITS     = 20;
	localparam int COORD_LIMIT    = 4096;
	localparam int COORD_W        = 12;
	localparam int SCALE_W        = 8;
	localparam int COLOR_W        = 24;
	localparam int CNT_W          = 5;
	localparam int FRAME_W        = 64;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 24;

	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SCALE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 4'd3;

	localparam logic [COORD_W-1:0] ORIGIN_X_RST    = 12'd10;
	localparam logic [COORD_W-1:0] ORIGIN_Y_RST    = 12'd10;
	localparam logic [SCALE_W-1:0] GLYPH_SCALE_RST = 8'd4;
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RST  = 24'hffffff;

	function automatic logic [63:0] glyph_bits(input logic [3:0] d);
		logic [63:0] g;
		case (d)
			4'd0: g = 64'h3c7e666666667e3c;
			4'd1: g = 64'h1838781818181818;
			4'd2: g = 64'h183c66460c183e7e;
			4'd3: g = 64'h3c7e063c3c067e3c;
			4'd4: g = 64'h0c1c34647e0c0c0c;
			4'd5: g = 64'h7e7e607c7e067e3c;
			4'd6: g = 64'h3c7e607c7e667e3c;
			4'd7: g = 64'h7e7e06060c0c1818;
			4'd8: g = 64'h3c7e663c3c667e3c;
			4'd9: g = 64'h3c7e667e3e067e3c;
			default: g = 64'd0;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/fno_if.sv
interface fno_in_if;
	import fno_pkg::*;
	logic               valid;
	logic               ready;
	logic               action;
	logic [FRAME_W-1:0] frame_number;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	modport source(output valid, output action, output frame_number, output pixel_x,
		output pixel_y, input ready);
	modport sink(input valid, input action, input frame_number, input pixel_x,
		input pixel_y, output ready);
endinterface

interface fno_out_if;
	import fno_pkg::*;
	logic             valid;
	logic             ready;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	logic             text_hit;
	logic [CNT_W-1:0] shown_digits;
	modport source(output valid, output red, output green, output blue, output text_hit,
		output shown_digits, input ready);
	modport sink(input valid, input red, input green, input blue, input text_hit,
		input shown_digits, output ready);
endinterface

interface fno_cfg_if;
	import fno_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/frame_number_overlay_top.sv
// Channel  Dir  Payload
// in_ch    in   action, frame_number[63:0], pixel_x[11:0], pixel_y[11:0]
// out_ch   out  red, green, blue, text_hit, shown_digits[4:0]
// cfg      in   index[3:0], data[23:0]; always ready
//
// Pixel query: 12 divide steps, then the result is loaded into the output register;
//   the next transaction is taken only once that result has been loaded.
//   The steps run on the shared bit-serial divider (x and y quotients, one bit per cycle).
// New frame: 64 shift-add-3 steps, then 1..20 normalize steps, then the result is loaded.
// in_ch.ready is high only when idle; a finished result waits in the output
//   register while out_ch stalls, and the next transaction may be taken then.
// arst_n clears control and digit count and loads the config defaults; no clearing pass.
`include "frame_number_overlay_top_assert.svh"

module frame_number_overlay_top #(
	parameter int MAX_DIGITS = fno_pkg::MAX_DIGITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fno_in_if.sink    in_ch,
	fno_out_if.source out_ch,
	fno_cfg_if.sink   cfg
);
	import fno_pkg::*;

	localparam int BCD_W = 4 * NUM_DIGITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DABBLE = 3'd1;
	localparam logic [2:0] ST_NORM   = 3'd2;
	localparam logic [2:0] ST_DIVIDE = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]         state_q;
	logic [5:0]         step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   digit_total_q;
	logic               action_q;
	logic               clip_q;
	logic [FRAME_W-1:0] num_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [COORD_W-1:0] qx_q, qy_q;
	logic [SCALE_W-1:0] rx_q, ry_q;

	logic [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [SCALE_W-1:0] scale_q;
	logic [COLOR_W-1:0] color_q;

	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_hit_q;
	logic [CNT_W-1:0]   out_shown_q;

	logic               in_acc;
	logic               out_load;
	logic [SCALE_W-1:0] scale_eff;
	logic [SCALE_W:0]   tx, ty;
	logic               gex, gey;
	logic [SCALE_W-1:0] rx_nxt, ry_nxt;
	logic [BCD_W-1:0]   bcd_adj;
	logic               top_zero;
	logic [8:0]         chr;
	logic [BCD_W-1:0]   dig_vec;
	logic [3:0]         digit;
	logic [63:0]        gbits;
	logic               hit;
	logic               clip_in;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// shared divider step, x and y lanes
	assign scale_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;
	assign tx        = {rx_q, qx_q[COORD_W-1]};
	assign ty        = {ry_q, qy_q[COORD_W-1]};
	assign gex       = tx >= {1'b0, scale_eff};
	assign gey       = ty >= {1'b0, scale_eff};
	assign rx_nxt    = gex ? SCALE_W'(tx - {1'b0, scale_eff}) : tx[SCALE_W-1:0];
	assign ry_nxt    = gey ? SCALE_W'(ty - {1'b0, scale_eff}) : ty[SCALE_W-1:0];

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	assign top_zero = (bcd_q[BCD_W-1 -: 4] == 4'd0);

	assign clip_in = ({5'd0, in_ch.pixel_x} >= 17'(COORD_LIMIT))
		|| ({5'd0, in_ch.pixel_y} >= 17'(COORD_LIMIT))
		|| (in_ch.pixel_x < origin_x_q) || (in_ch.pixel_y < origin_y_q);

	// glyph lookup
	assign chr     = qx_q[COORD_W-1:3];
	assign dig_vec = bcd_q << {chr[4:0], 2'b00};
	assign digit   = dig_vec[BCD_W-1 -: 4];
	assign gbits   = glyph_bits(digit);
	assign hit     = (action_q == ACT_PIXEL) && !clip_q
		&& (qy_q < COORD_W'(8))
		&& (chr < {4'd0, digit_total_q})
		&& (chr < 9'(MAX_DIGITS))
		&& (digit <= 4'd9)
		&& gbits[{~qy_q[2:0], ~qx_q[2:0]}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			cnt_q         <= '0;
			digit_total_q <= '0;
			out_valid_q   <= 1'b0;
			origin_x_q    <= ORIGIN_X_RST;
			origin_y_q    <= ORIGIN_Y_RST;
			scale_q       <= GLYPH_SCALE_RST;
			color_q       <= TEXT_COLOR_RST;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_ORIGIN_X:    origin_x_q <= cfg.data[COORD_W-1:0];
					REG_ORIGIN_Y:    origin_y_q <= cfg.data[COORD_W-1:0];
					REG_GLYPH_SCALE: scale_q    <= cfg.data[SCALE_W-1:0];
					REG_TEXT_COLOR:  color_q    <= cfg.data[COLOR_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q  <= '0;
						state_q <= (in_ch.action == ACT_FRAME) ? ST_DABBLE : ST_DIVIDE;
					end
				end
				ST_DABBLE: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'(FRAME_W - 1)) begin
						cnt_q   <= CNT_W'(NUM_DIGITS);
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (top_zero && cnt_q != CNT_W'(1)) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						digit_total_q <= (cnt_q > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
							: cnt_q;
						state_q <= ST_DONE;
					end
				end
				ST_DIVIDE: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'(COORD_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					action_q <= in_ch.action;
					num_q    <= in_ch.frame_number;
					if (in_ch.action == ACT_FRAME) begin
						bcd_q <= '0;
					end
					clip_q   <= clip_in;
					qx_q     <= in_ch.pixel_x - origin_x_q;
					qy_q     <= in_ch.pixel_y - origin_y_q;
					rx_q     <= '0;
					ry_q     <= '0;
				end
			end
			ST_DABBLE: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], num_q[FRAME_W-1]};
				num_q <= {num_q[FRAME_W-2:0], 1'b0};
			end
			ST_NORM: begin
				if (top_zero && cnt_q != CNT_W'(1)) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			ST_DIVIDE: begin
				rx_q <= rx_nxt;
				ry_q <= ry_nxt;
				qx_q <= {qx_q[COORD_W-2:0], gex};
				qy_q <= {qy_q[COORD_W-2:0], gey};
			end
			ST_DONE: begin
				if (out_load) begin
					out_color_q <= hit ? color_q : '0;
					out_hit_q   <= hit;
					out_shown_q <= digit_total_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.red          = out_color_q[23:16];
	assign out_ch.green        = out_color_q[15:8];
	assign out_ch.blue         = out_color_q[7:0];
	assign out_ch.text_hit     = out_hit_q;
	assign out_ch.shown_digits = out_shown_q;

	`FNO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "ready high right after a transaction")
	`FNO_ASSERT_IMPLY(a_hit_has_digits, clk, arst_n, out_ch.valid && out_ch.text_hit, out_ch.shown_digits != '0 && out_ch.shown_digits <= CNT_W'(MAX_DIGITS), "text hit with no valid digit count")
	`FNO_ASSERT_IMPLY(a_convert_on_frame, clk, arst_n, state_q == ST_DABBLE || state_q == ST_NORM, action_q == ACT_FRAME, "digit conversion on a pixel query")

endmodule
